// ===== src/acr_pkg.sv =====
package acr_pkg;

  localparam int COORD_W    = 24;
  localparam int SIZE_W     = 23;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int USED_W     = 7;
  // coordinate plus size plus one guard bit
  localparam int WIDE_W     = 26;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [SIZE_W-1:0]  size_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  localparam wide_t COORD_MAX_W = 26'sd8388607;
  localparam wide_t COORD_MIN_W = -26'sd8388608;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALL_STEP    = 1'd0,
    CFG_FLOOR_HEIGHT = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

endpackage

// ===== src/acr_in_if.sv =====
interface acr_in_if
  import acr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  coord_t            pos_x;
  coord_t            pos_y;
  coord_t            pos_z;
  size_t             size_x;
  size_t             size_y;
  size_t             size_z;
  size_t             radius;
  size_t             body_height;
  size_t             ground_step;

  modport source (
    output valid, opcode, pos_x, pos_y, pos_z, size_x, size_y, size_z,
           radius, body_height, ground_step,
    input  ready
  );

  modport sink (
    input  valid, opcode, pos_x, pos_y, pos_z, size_x, size_y, size_z,
           radius, body_height, ground_step,
    output ready
  );
endinterface

// ===== src/acr_out_if.sv =====
interface acr_out_if
  import acr_pkg::*;
;
  logic              valid;
  logic              ready;
  coord_t            new_x;
  coord_t            new_z;
  coord_t            ground_y;
  logic              ground_found;
  logic              at_ground;
  logic              table_full;
  logic [USED_W-1:0] boxes_used;

  modport source (
    output valid, new_x, new_z, ground_y, ground_found, at_ground, table_full,
           boxes_used,
    input  ready
  );

  modport sink (
    input  valid, new_x, new_z, ground_y, ground_found, at_ground, table_full,
           boxes_used,
    output ready
  );
endinterface

// ===== src/acr_ram.sv =====
module acr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/aabb_collision_resolver_core.sv =====
// aabb box table with actor push-out and ground-height search
//
// in_word (valid/ready) takes one command word: clear, append or query.
// out_word (valid/ready) returns exactly one result word per command.
// cfg_we/cfg_idx/cfg_wdata write wall_step (index 0) or floor_height
// (index 1); the user must write only while the block is idle; not enforced.
//
// commands run one at a time through a small sequencer around a single
// box-evaluation datapath and one box ram (one read port, registered).
// work done per command before the result register loads:
//   clear  : goes straight to the done state
//   append : the append state writes the box, then the done state
//   query  : a setup state, then the push-out walk steps through bounds,
//            inside test and face select for each box, since each box sees
//            the position left by the one before, then the ground walk
//            visits each box once
// in_word.ready is high only while the sequencer is idle; a finished result
// sits in the output register, so the next word is taken while it waits.
// a stalled receiver holds the result; a new result waits in the done
// state until the output register is free.
// reset empties the table (count to zero, ram contents left as they are),
// sets wall_step to 2.0 and floor_height to 0; no clearing pass is needed.
module aabb_collision_resolver_core
  import acr_pkg::*;
#(
  parameter int MAX_BOXES = 64,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  acr_in_if.sink                in_word,
  acr_out_if.source             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BOXES);
  localparam size_t WALL_STEP_RST = SIZE_W'(2 << FRAC_BITS);
  localparam int BOX_W = $bits(box_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_PREP,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_PUSH_C,
    ST_GROUND,
    ST_DONE
  } state_t;

  // sign / zero extension into the wide working format
  function automatic wide_t sx(input coord_t v);
    sx = {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic wide_t zx(input size_t v);
    zx = {{(WIDE_W-SIZE_W){1'b0}}, v};
  endfunction

  function automatic coord_t sat_c(input wide_t v);
    if (v > COORD_MAX_W) begin
      sat_c = COORD_MAX_W[COORD_W-1:0];
    end else if (v < COORD_MIN_W) begin
      sat_c = COORD_MIN_W[COORD_W-1:0];
    end else begin
      sat_c = v[COORD_W-1:0];
    end
  endfunction

  // control and output registers
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  size_t             wall_step_r, wall_step_nxt;
  coord_t            floor_r, floor_nxt;
  logic              out_valid_r, out_valid_nxt;
  coord_t            out_x_r, out_x_nxt;
  coord_t            out_z_r, out_z_nxt;
  coord_t            out_gy_r, out_gy_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_atg_r, out_atg_nxt;
  logic              out_full_r, out_full_nxt;
  logic [USED_W-1:0] out_used_r, out_used_nxt;

  // captured command word
  logic [OP_W-1:0]   op_r, op_nxt;
  coord_t            px_r, px_nxt;
  coord_t            py_r, py_nxt;
  coord_t            pz_r, pz_nxt;
  size_t             sx_r, sx_nxt;
  size_t             sy_r, sy_nxt;
  size_t             sz_r, sz_nxt;
  size_t             rad_r, rad_nxt;
  size_t             bh_r, bh_nxt;
  size_t             gs_r, gs_nxt;

  // walk datapath
  wide_t             py_bh_r, py_bh_nxt;
  wide_t             py_ws_r, py_ws_nxt;
  wide_t             py_gs_r, py_gs_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  coord_t            nx_r, nx_nxt;
  coord_t            nz_r, nz_nxt;
  logic              vert_r, vert_nxt;
  wide_t             lx_r, lx_nxt;
  wide_t             hx_r, hx_nxt;
  wide_t             lz_r, lz_nxt;
  wide_t             hz_r, hz_nxt;
  logic              inside_r, inside_nxt;
  wide_t             dl_r, dl_nxt;
  wide_t             dr_r, dr_nxt;
  wide_t             df_r, df_nxt;
  wide_t             db_r, db_nxt;
  coord_t            best_r, best_nxt;
  logic              found_r, found_nxt;
  logic              full_r, full_nxt;

  // box ram
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  box_t              ram_wdata;
  box_t              ram_rdata;

  // helpers
  logic              is_query;
  logic              walk_last;
  logic [AW-1:0]     idx_inc;
  logic              pick_l, pick_r, pick_f;
  logic              ground_hit;
  coord_t            gy_sel;

  acr_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign is_query  = (op_r == OP_QUERY);
  assign idx_inc   = idx_r + 1'b1;
  assign walk_last = ((CW'(idx_r) + 1'b1) == count_r);

  // new box bounds from base-center and size, half widths truncated
  assign ram_wdata.min_x = sat_c(sx(px_r) - zx(sx_r >> 1));
  assign ram_wdata.min_y = py_r;
  assign ram_wdata.min_z = sat_c(sx(pz_r) - zx(sz_r >> 1));
  assign ram_wdata.max_x = sat_c(sx(px_r) + zx(sx_r >> 1));
  assign ram_wdata.max_y = sat_c(sx(py_r) + zx(sy_r));
  assign ram_wdata.max_z = sat_c(sx(pz_r) + zx(sz_r >> 1));

  // nearest face, ties left, right, front, back
  assign pick_l = (dl_r <= dr_r) && (dl_r <= df_r) && (dl_r <= db_r);
  assign pick_r = (dr_r <= df_r) && (dr_r <= db_r);
  assign pick_f = (df_r <= db_r);

  assign ground_hit = (nx_r >= ram_rdata.min_x) && (nx_r <= ram_rdata.max_x) &&
                      (nz_r >= ram_rdata.min_z) && (nz_r <= ram_rdata.max_z) &&
                      (py_gs_r >= sx(ram_rdata.max_y));

  assign gy_sel = is_query ? (found_r ? best_r : floor_r) : '0;

  assign in_word.ready         = (state_r == ST_IDLE);
  assign out_word.valid        = out_valid_r;
  assign out_word.new_x        = out_x_r;
  assign out_word.new_z        = out_z_r;
  assign out_word.ground_y     = out_gy_r;
  assign out_word.ground_found = out_found_r;
  assign out_word.at_ground    = out_atg_r;
  assign out_word.table_full   = out_full_r;
  assign out_word.boxes_used   = out_used_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wall_step_nxt = wall_step_r;
    floor_nxt     = floor_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_x_nxt     = out_x_r;
    out_z_nxt     = out_z_r;
    out_gy_nxt    = out_gy_r;
    out_found_nxt = out_found_r;
    out_atg_nxt   = out_atg_r;
    out_full_nxt  = out_full_r;
    out_used_nxt  = out_used_r;
    op_nxt        = op_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    sz_nxt        = sz_r;
    rad_nxt       = rad_r;
    bh_nxt        = bh_r;
    gs_nxt        = gs_r;
    py_bh_nxt     = py_bh_r;
    py_ws_nxt     = py_ws_r;
    py_gs_nxt     = py_gs_r;
    idx_nxt       = idx_r;
    nx_nxt        = nx_r;
    nz_nxt        = nz_r;
    vert_nxt      = vert_r;
    lx_nxt        = lx_r;
    hx_nxt        = hx_r;
    lz_nxt        = lz_r;
    hz_nxt        = hz_r;
    inside_nxt    = inside_r;
    dl_nxt        = dl_r;
    dr_nxt        = dr_r;
    df_nxt        = df_r;
    db_nxt        = db_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    full_nxt      = full_r;
    ram_we        = 1'b0;
    ram_raddr     = idx_r;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_WALL_STEP:    wall_step_nxt = cfg_wdata[SIZE_W-1:0];
        CFG_FLOOR_HEIGHT: floor_nxt     = cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_word.valid) begin
          op_nxt    = in_word.opcode;
          px_nxt    = in_word.pos_x;
          py_nxt    = in_word.pos_y;
          pz_nxt    = in_word.pos_z;
          sx_nxt    = in_word.size_x;
          sy_nxt    = in_word.size_y;
          sz_nxt    = in_word.size_z;
          rad_nxt   = in_word.radius;
          bh_nxt    = in_word.body_height;
          gs_nxt    = in_word.ground_step;
          nx_nxt    = '0;
          nz_nxt    = '0;
          found_nxt = 1'b0;
          full_nxt  = 1'b0;
          case (op_t'(in_word.opcode))
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
            OP_APPEND: state_nxt = ST_APPEND;
            OP_QUERY: begin
              nx_nxt    = in_word.pos_x;
              nz_nxt    = in_word.pos_z;
              state_nxt = ST_PREP;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_APPEND: begin
        if (count_r == CNT_MAX) begin
          full_nxt = 1'b1;
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_PREP: begin
        // actor span sums shared by every box of the walk
        py_bh_nxt = sx(py_r) + zx(bh_r);
        py_ws_nxt = sx(py_r) + zx(wall_step_r);
        py_gs_nxt = sx(py_r) + zx(gs_r);
        idx_nxt   = '0;
        ram_raddr = '0;
        state_nxt = (count_r == '0) ? ST_DONE : ST_PUSH_A;
      end
      ST_PUSH_A: begin
        vert_nxt  = (py_bh_r > sx(ram_rdata.min_y)) && (py_ws_r < sx(ram_rdata.max_y));
        lx_nxt    = sx(ram_rdata.min_x) - zx(rad_r);
        hx_nxt    = sx(ram_rdata.max_x) + zx(rad_r);
        lz_nxt    = sx(ram_rdata.min_z) - zx(rad_r);
        hz_nxt    = sx(ram_rdata.max_z) + zx(rad_r);
        state_nxt = ST_PUSH_B;
      end
      ST_PUSH_B: begin
        inside_nxt = vert_r && (sx(nx_r) > lx_r) && (sx(nx_r) < hx_r) &&
                     (sx(nz_r) > lz_r) && (sx(nz_r) < hz_r);
        dl_nxt     = sx(nx_r) - lx_r;
        dr_nxt     = hx_r - sx(nx_r);
        df_nxt     = sx(nz_r) - lz_r;
        db_nxt     = hz_r - sx(nz_r);
        state_nxt  = ST_PUSH_C;
      end
      ST_PUSH_C: begin
        if (inside_r) begin
          if (pick_l) begin
            nx_nxt = sat_c(lx_r);
          end else if (pick_r) begin
            nx_nxt = sat_c(hx_r);
          end else if (pick_f) begin
            nz_nxt = sat_c(lz_r);
          end else begin
            nz_nxt = sat_c(hz_r);
          end
        end
        if (walk_last) begin
          idx_nxt   = '0;
          ram_raddr = '0;
          state_nxt = ST_GROUND;
        end else begin
          idx_nxt   = idx_inc;
          ram_raddr = idx_inc;
          state_nxt = ST_PUSH_A;
        end
      end
      ST_GROUND: begin
        // an equal later top keeps the earlier one
        if (ground_hit && (!found_r || (ram_rdata.max_y > best_r))) begin
          best_nxt  = ram_rdata.max_y;
          found_nxt = 1'b1;
        end
        if (walk_last) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_inc;
          ram_raddr = idx_inc;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_word.ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = nx_r;
          out_z_nxt     = nz_r;
          out_gy_nxt    = gy_sel;
          out_found_nxt = is_query && found_r;
          out_atg_nxt   = is_query && (py_r <= gy_sel);
          out_full_nxt  = full_r;
          out_used_nxt  = USED_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer state, table count, config and the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      wall_step_r <= WALL_STEP_RST;
      floor_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wall_step_r <= wall_step_nxt;
      floor_r     <= floor_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_x_r     <= out_x_nxt;
    out_z_r     <= out_z_nxt;
    out_gy_r    <= out_gy_nxt;
    out_found_r <= out_found_nxt;
    out_atg_r   <= out_atg_nxt;
    out_full_r  <= out_full_nxt;
    out_used_r  <= out_used_nxt;
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    pz_r     <= pz_nxt;
    sx_r     <= sx_nxt;
    sy_r     <= sy_nxt;
    sz_r     <= sz_nxt;
    rad_r    <= rad_nxt;
    bh_r     <= bh_nxt;
    gs_r     <= gs_nxt;
    py_bh_r  <= py_bh_nxt;
    py_ws_r  <= py_ws_nxt;
    py_gs_r  <= py_gs_nxt;
    idx_r    <= idx_nxt;
    nx_r     <= nx_nxt;
    nz_r     <= nz_nxt;
    vert_r   <= vert_nxt;
    lx_r     <= lx_nxt;
    hx_r     <= hx_nxt;
    lz_r     <= lz_nxt;
    hz_r     <= hz_nxt;
    inside_r <= inside_nxt;
    dl_r     <= dl_nxt;
    dr_r     <= dr_nxt;
    df_r     <= df_nxt;
    db_r     <= db_nxt;
    best_r   <= best_nxt;
    found_r  <= found_nxt;
    full_r   <= full_nxt;
  end

  // table never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("box count above capacity");

  // an accepted word always starts work, the sequencer leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_word.valid && in_word.ready) |=> (state_r != ST_IDLE))
    else $error("accepted word did not start the sequencer");

  // a dropped append only ever reports a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && out_word.table_full) |->
      (out_word.boxes_used == USED_W'(MAX_BOXES)))
    else $error("table_full with a table that is not full");

  // walk index stays inside the held boxes
  a_walk_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH_A || state_r == ST_PUSH_B || state_r == ST_PUSH_C ||
     state_r == ST_GROUND) |-> (CW'(idx_r) < count_r))
    else $error("walk index beyond box count");

endmodule
